[rtl/core/ifga_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifga_pkg
// Shared widths and types for the IMU frame to gimbal attitude block.
// ----------------------------------------------------------------------------
package ifga_pkg;

  localparam int unsigned WordW     = 16;
  localparam int unsigned WideW     = 17;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned SumW      = 2 * WordW;
  localparam int unsigned RootW     = WordW;
  localparam int unsigned StepCntW  = $clog2(WordW);
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 104;

  localparam logic FuncAngle = 1'b0;
  localparam logic FuncSpeed = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] rate_ready;
    logic [ByteW-1:0] attitude_ready;
    logic [WideW-1:0] fused_yaw_rate;
    logic [WordW-1:0] gimbal_pitch_rate;
    logic [WordW-1:0] gimbal_roll;
    logic [WordW-1:0] gimbal_yaw;
    logic [WideW-1:0] gimbal_pitch;
  } result_t;

  // magnitude of a signed word, -32768 maps to 32768
  function automatic logic [WordW-1:0] mag(input logic [WordW-1:0] v);
    logic [WordW-1:0] neg;
    neg = ~v + WordW'(1);
    return v[WordW-1] ? neg : v;
  endfunction

endpackage

[rtl/core/ifga_sqsum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifga_sqsum
// Bit-serial sum of squares of two signed words, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module ifga_sqsum (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ifga_pkg::WordW-1:0] yaw_i,
  input  logic [ifga_pkg::WordW-1:0] roll_i,
  output logic [ifga_pkg::SumW-1:0]  sum_o,
  output logic                   done_o
);
  import ifga_pkg::*;

  logic [WordW-1:0]    ya_q, ra_q, ym_q, rm_q;
  logic [SumW:0]       acc_q, acc_d;
  logic [StepCntW-1:0] cnt_q;
  logic                busy_q, done_q;
  logic [WideW:0]      part;

  // both partial products land in the upper half, then the accumulator shifts
  always_comb begin
    part  = {1'b0, acc_q[SumW:WordW]}
          + (ym_q[0] ? {2'b00, ya_q} : '0)
          + (rm_q[0] ? {2'b00, ra_q} : '0);
    acc_d = {part, acc_q[WordW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ya_q   <= '0;
      ra_q   <= '0;
      ym_q   <= '0;
      rm_q   <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        ya_q   <= mag(yaw_i);
        ra_q   <= mag(roll_i);
        ym_q   <= mag(yaw_i);
        rm_q   <= mag(roll_i);
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= acc_d;
        ym_q  <= ym_q >> 1;
        rm_q  <= rm_q >> 1;
        cnt_q <= cnt_q + StepCntW'(1);
        if (cnt_q == StepCntW'(WordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sum_o  = acc_q[SumW-1:0];
  assign done_o = done_q;

endmodule

[rtl/core/ifga_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifga_isqrt
// Restoring floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ifga_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ifga_pkg::SumW-1:0]   rad_i,
  output logic [ifga_pkg::RootW-1:0]  root_o,
  output logic                        done_o
);
  import ifga_pkg::*;

  logic [SumW-1:0]     rad_q;
  logic [RootW-1:0]    root_q;
  logic [RootW:0]      rem_q;
  logic [StepCntW-1:0] cnt_q;
  logic                busy_q, done_q;
  logic [RootW+2:0]    rem_t, trial, diff;
  logic                ge;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rem_t = {rem_q, rad_q[SumW-1:SumW-2]};
    trial = {1'b0, root_q, 2'b01};
    ge    = (rem_t >= trial);
    diff  = rem_t - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= rad_i;
        root_q <= '0;
        rem_q  <= '0;
      end else if (busy_q) begin
        rad_q  <= {rad_q[SumW-3:0], 2'b00};
        rem_q  <= ge ? diff[RootW:0] : rem_t[RootW:0];
        root_q <= {root_q[RootW-2:0], ge};
        cnt_q  <= cnt_q + StepCntW'(1);
        if (cnt_q == StepCntW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

[rtl/core/imu_frame_to_gimbal_attitude_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_to_gimbal_attitude_top
// Stores IMU angle frames and turns speed frames into gimbal attitude beats.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one decoded IMU frame per beat; tuser says angle (0) or
//   angular speed (1). An angle beat only updates the stored pitch, yaw,
//   roll and ready byte and gives no output beat; the input stays ready.
//   A speed beat gives one m_axis beat with the stored attitude less the
//   pitch offset, the pitch rate and the signed fused yaw rate.
//   The cfg channel writes the pitch offset; it is always ready and is
//   meant to be written while the block is idle.
//   A speed beat's squares are summed bit-serially, then the root takes one
//   bit per cycle; the sum's done launches the root, and the root's done
//   hands the result off to the output register, which raises m_axis_tvalid.
//   One speed beat is in flight at a time, so the input is not ready again
//   until that beat's result has been handed off to the output register.
//   The output beat sits in its own register; the next frame is accepted
//   while it waits. If the receiver stalls, a finished result holds inside
//   until the output register drains.
//   Reset clears the stored attitude, the offset and all valid flags.
// ----------------------------------------------------------------------------
module imu_frame_to_gimbal_attitude_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write: pitch_offset
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ifga_pkg::WordW-1:0]       cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // pitch_word, yaw_word, roll_word, ready_byte
  input  logic [ifga_pkg::InTdataW-1:0]    s_axis_tdata_i,
  // func
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // gimbal_pitch, gimbal_yaw, gimbal_roll, gimbal_pitch_rate,
  // fused_yaw_rate, attitude_ready, rate_ready, zero pad
  output logic [ifga_pkg::OutTdataW-1:0]   m_axis_tdata_o
);
  import ifga_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_HOLD
  } state_e;

  state_e            state_q;
  logic [WordW-1:0]  offset_q;
  logic [WordW-1:0]  st_pitch_q, st_yaw_q, st_roll_q;
  logic [ByteW-1:0]  st_ready_q;
  result_t           res_q, res_d;
  logic              yaw_pos_q;
  logic              out_valid_q;
  logic [OutTdataW-1:0] out_data_q;

  logic [WordW-1:0]  in_pitch, in_yaw, in_roll;
  logic [ByteW-1:0]  in_ready;
  logic              s_acc, speed_acc, slot_free, out_load;
  logic [SumW-1:0]   sum;
  logic              sq_done, rt_done;
  logic [RootW-1:0]  root;
  logic [WideW-1:0]  root_ext;

  assign in_pitch = s_axis_tdata_i[WordW-1:0];
  assign in_yaw   = s_axis_tdata_i[2*WordW-1:WordW];
  assign in_roll  = s_axis_tdata_i[3*WordW-1:2*WordW];
  assign in_ready = s_axis_tdata_i[3*WordW+ByteW-1:3*WordW];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign speed_acc = s_acc && (s_axis_tuser_i == FuncSpeed);
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign out_load  = slot_free && (((state_q == ST_ROOT) && rt_done) || (state_q == ST_HOLD));
  assign cfg_ready_o = 1'b1;

  ifga_sqsum u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (speed_acc),
    .yaw_i   (in_yaw),
    .roll_i  (in_roll),
    .sum_o   (sum),
    .done_o  (sq_done)
  );

  ifga_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_done),
    .rad_i   (sum),
    .root_o  (root),
    .done_o  (rt_done)
  );

  // zero yaw rate counts as negative
  always_comb begin
    root_ext = {1'b0, root};
    res_d    = res_q;
    res_d.fused_yaw_rate = yaw_pos_q ? root_ext : (~root_ext + WideW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      offset_q    <= '0;
      st_pitch_q  <= '0;
      st_yaw_q    <= '0;
      st_roll_q   <= '0;
      st_ready_q  <= '0;
      res_q       <= '0;
      yaw_pos_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        offset_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc && (s_axis_tuser_i == FuncAngle)) begin
            st_pitch_q <= in_pitch;
            st_yaw_q   <= in_yaw;
            st_roll_q  <= in_roll;
            st_ready_q <= in_ready;
          end else if (speed_acc) begin
            res_q.gimbal_pitch      <= {st_pitch_q[WordW-1], st_pitch_q}
                                     - {offset_q[WordW-1], offset_q};
            res_q.gimbal_yaw        <= st_yaw_q;
            res_q.gimbal_roll       <= st_roll_q;
            res_q.gimbal_pitch_rate <= in_pitch;
            res_q.attitude_ready    <= st_ready_q;
            res_q.rate_ready        <= in_ready;
            res_q.fused_yaw_rate    <= '0;
            yaw_pos_q <= !in_yaw[WordW-1] && (in_yaw != '0);
            state_q   <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (sq_done) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (rt_done) begin
            res_q <= res_d;
            if (slot_free) begin
              out_data_q  <= {{(OutTdataW - $bits(result_t)){1'b0}}, res_d};
              state_q     <= ST_IDLE;
            end else begin
              state_q <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          // root already folded into res_q
          if (slot_free) begin
            out_data_q  <= {{(OutTdataW - $bits(result_t)){1'b0}}, res_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[test/tb_imu_frame_to_gimbal_attitude_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_frame_to_gimbal_attitude_top
// Self-checking bench for the IMU frame to gimbal attitude block. It drives
// angle and speed frames, writes the pitch offset between phases while the
// block is idle, and checks every attitude beat field by field against a
// model of the stored attitude and the signed fused yaw rate.
// ----------------------------------------------------------------------------
module tb_imu_frame_to_gimbal_attitude_top;
  import ifga_pkg::*;

  localparam int unsigned HalfPeriod      = 6;
  localparam int unsigned ResetCycles     = 11;
  localparam int unsigned DrainCycles     = 40;
  localparam int unsigned StallLimit      = 4000;
  localparam int unsigned ItemsPerSegment = 217;

  class attitude_scoreboard;
    logic signed [WordW-1:0] pitch_offset = '0;
    logic signed [WordW-1:0] pitch_q      = '0;
    logic signed [WordW-1:0] yaw_q        = '0;
    logic signed [WordW-1:0] roll_q       = '0;
    logic [ByteW-1:0]        att_rdy_q    = '0;
    result_t                 attitude_q[$];
    int unsigned             errors       = 0;
    int unsigned             frames       = 0;
    int unsigned             results      = 0;
    int unsigned             offset_writes = 0;

    function int unsigned pending();
      return attitude_q.size();
    endfunction

    function void set_offset(logic [WordW-1:0] v);
      pitch_offset = v;
      offset_writes++;
    endfunction

    // floor root of y^2 + r^2, negated unless the yaw rate is above zero
    function logic [WideW-1:0] fused_rate(logic signed [WordW-1:0] y,
                                          logic signed [WordW-1:0] r);
      longint          ys;
      longint          rs;
      longint          sum;
      logic [WideW-1:0] root;
      logic [WideW-1:0] trial;
      ys   = y;
      rs   = r;
      sum  = ys * ys + rs * rs;
      root = '0;
      for (int b = RootW - 1; b >= 0; b--) begin
        trial = root | (WideW'(1) << b);
        if (longint'(trial) * longint'(trial) <= sum) root = trial;
      end
      if (y > 0) return root;
      return -root;
    endfunction

    function void note_frame(logic func, logic [WordW-1:0] p, logic [WordW-1:0] y,
                             logic [WordW-1:0] r, logic [ByteW-1:0] rdy);
      result_t exp_r;
      frames++;
      if (func == FuncAngle) begin
        pitch_q   = p;
        yaw_q     = y;
        roll_q    = r;
        att_rdy_q = rdy;
      end else begin
        exp_r.gimbal_pitch      = WideW'(longint'(pitch_q) - longint'(pitch_offset));
        exp_r.gimbal_yaw        = yaw_q;
        exp_r.gimbal_roll       = roll_q;
        exp_r.gimbal_pitch_rate = p;
        exp_r.fused_yaw_rate    = fused_rate(y, r);
        exp_r.attitude_ready    = att_rdy_q;
        exp_r.rate_ready        = rdy;
        attitude_q.push_back(exp_r);
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string name, logic [WideW-1:0] got, logic [WideW-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s got %h want %h", results, name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (attitude_q.size() == 0) begin
        report_mismatch("attitude beat with nothing outstanding");
        return;
      end
      want = attitude_q.pop_front();
      compare_field("gimbal_pitch", got.gimbal_pitch, want.gimbal_pitch);
      compare_field("gimbal_yaw", got.gimbal_yaw, want.gimbal_yaw);
      compare_field("gimbal_roll", got.gimbal_roll, want.gimbal_roll);
      compare_field("gimbal_pitch_rate", got.gimbal_pitch_rate, want.gimbal_pitch_rate);
      compare_field("fused_yaw_rate", got.fused_yaw_rate, want.fused_yaw_rate);
      compare_field("attitude_ready", got.attitude_ready, want.attitude_ready);
      compare_field("rate_ready", got.rate_ready, want.rate_ready);
      results++;
    endtask
  endclass

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WordW-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata   = '0;  // pitch, yaw, roll, ready byte
  logic                 s_tuser   = 1'b0; // func
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OutTdataW-1:0] m_tdata;          // result_t fields, zero pad on top

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned stall_cycles  = 0;

  attitude_scoreboard sb = new;

  always #(HalfPeriod) clk_i = ~clk_i;

  imu_frame_to_gimbal_attitude_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(result_t'(m_tdata[$bits(result_t)-1:0]));
  end

  // watchdog on cycles in which no beat moves on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("timeout: no beat for %0d cycles", StallLimit);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  task automatic drive_frame(input logic func, input logic [WordW-1:0] p,
                             input logic [WordW-1:0] y, input logic [WordW-1:0] r,
                             input logic [ByteW-1:0] rdy);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tuser  = func;
    s_tdata  = {rdy, r, y, p};
    do @(posedge clk_i); while (!s_tready);
    sb.note_frame(func, p, y, r, rdy);
    @(negedge clk_i);
  endtask

  // offset only changes once the pipeline has emptied
  task automatic write_offset(input logic [WordW-1:0] v);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_offset(v);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [WordW-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'hFFFF;
          2:       return 16'h0000;
          3:       return 16'h0001;
          default: return 16'h7FFF;
        endcase
      end
      1, 2:    return WordW'(int'($urandom_range(0, 400)) - 200);
      default: return WordW'($urandom);
    endcase
  endfunction

  initial begin
    logic func;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    src_idle_pct  = 19;
    sink_idle_pct = 68;

    // speed frames against the reset attitude, then the root corners
    drive_frame(FuncSpeed, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    drive_frame(FuncSpeed, 16'h7FFF, 16'h8000, 16'h8000, 8'hFF);
    drive_frame(FuncAngle, 16'h7FFF, 16'h8000, 16'h7FFF, 8'hFF);
    drive_frame(FuncSpeed, 16'h8000, 16'h0000, 16'hFFFB, 8'h5A);
    drive_frame(FuncSpeed, 16'h0001, 16'h7FFF, 16'h7FFF, 8'hA5);
    drive_frame(FuncSpeed, 16'hFFFF, 16'h0001, 16'h0000, 8'h01);
    drive_frame(FuncSpeed, 16'h0000, 16'hFFFF, 16'h0000, 8'h80);
    // offsets beyond the nominal range push the pitch to the 17-bit ends
    write_offset(16'h8000);
    drive_frame(FuncSpeed, 16'h1234, 16'h0003, 16'h0004, 8'h7F);
    drive_frame(FuncAngle, 16'h8000, 16'h7FFF, 16'h8000, 8'h00);
    write_offset(16'h7FFF);
    drive_frame(FuncSpeed, 16'h8000, 16'h8000, 16'h0000, 8'hC3);
    drive_frame(FuncAngle, 16'h0000, 16'h0000, 16'h0000, 8'hA5);
    drive_frame(FuncSpeed, 16'h7FFF, 16'h7FFF, 16'h8000, 8'h3C);
    write_offset(16'(18000));
    drive_frame(FuncAngle, 16'(-18000), 16'(-18000), 16'(18000), 8'h55);
    drive_frame(FuncSpeed, 16'h0000, 16'h0000, 16'h0000, 8'hAA);
    drive_frame(FuncSpeed, 16'h0064, 16'h8000, 16'h7FFF, 8'hF0);
    write_offset(16'(-18000));
    drive_frame(FuncAngle, 16'(18000), 16'h0001, 16'hFFFF, 8'h0F);
    drive_frame(FuncSpeed, 16'hFF9C, 16'hFFFD, 16'h0004, 8'h01);

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0:       begin src_idle_pct = 19; sink_idle_pct = 68; end
        1:       begin src_idle_pct = 68; sink_idle_pct = 19; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      case (seg)
        0:       write_offset(16'(-18000));
        1:       write_offset(WordW'($urandom));
        2:       write_offset(16'h0000);
        3:       write_offset(WordW'(int'($urandom_range(0, 36000)) - 18000));
        4:       write_offset(16'(18000));
        default: write_offset(WordW'($urandom));
      endcase
      repeat (ItemsPerSegment) begin
        func = ($urandom_range(0, 99) < 40) ? FuncAngle : FuncSpeed;
        drive_frame(func, pick_word(), pick_word(), pick_word(), ByteW'($urandom));
      end
    end

    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("ran %0d frames giving %0d attitude beats over %0d pitch offset settings",
             sb.frames, sb.results, sb.offset_writes);
    $display("flow control: slow sender, slow receiver and back-to-back; %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[imu_frame_to_gimbal_attitude_top.f]
rtl/core/ifga_pkg.sv
rtl/core/ifga_sqsum.sv
rtl/core/ifga_isqrt.sv
rtl/core/imu_frame_to_gimbal_attitude_top.sv
test/tb_imu_frame_to_gimbal_attitude_top.sv
